// ===== hdl/chkc_pkg.sv =====
// ============================================================================
// chkc_pkg
// Shared types and constants of the chained hash key counter: payload
// structs, command and status codes, table geometry and the constants of
// the bucket hash.
// ============================================================================
package chkc_pkg;

   localparam int BUCKETS      = 211;
   localparam int POOL_ENTRIES = 256;
   localparam int KEY_BITS     = 24;
   localparam int COUNT_BITS   = 24;

   localparam int SLOT_BITS   = $clog2(POOL_ENTRIES);
   localparam int USED_BITS   = $clog2(POOL_ENTRIES + 1);
   localparam int BUCKET_BITS = $clog2(BUCKETS);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // key mod BUCKETS: fold the three key bytes with 256^i mod BUCKETS, then
   // reduce the small sum by a reciprocal multiply and one correction step
   localparam int FOLD1       = 256 % BUCKETS;
   localparam int FOLD2       = 65536 % BUCKETS;
   localparam int X_BITS      = 16;
   localparam int RECIP_SHIFT = 23;
   localparam int RECIP       = (1 << RECIP_SHIFT) / BUCKETS;
   localparam int Q_BITS      = 8;

   typedef enum logic [1:0] {
      CMD_COUNT = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_FOUND    = 3'd0,
      ST_INSERTED = 3'd1,
      ST_FULL     = 3'd2,
      ST_READ     = 3'd3,
      ST_UNUSED   = 3'd4,
      ST_CLEARED  = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]          command;
      logic [KEY_BITS-1:0] key;
      logic [7:0]          slot;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [7:0]            entry_index;
      logic [KEY_BITS-1:0]   entry_key_out;
      logic [COUNT_BITS-1:0] entry_count_out;
      logic [8:0]            entries_used;
   } rsp_type;

   // request with its bucket, as handed from front to back
   typedef struct packed {
      req_type                req;
      logic [BUCKET_BITS-1:0] bucket;
   } cls_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_FOLD,
      FR_QUOT,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_HEAD,
      BK_WALK,
      BK_MISS,
      BK_READ
   } back_state_type;

endpackage

// ===== hdl/chained_hash_key_counter_unit.sv =====
// ============================================================================
// chained_hash_key_counter_unit
// Hash table with separate chaining that counts key occurrences.
// ============================================================================
// A request passes through the front (accept, then fold and quotient steps
// to reduce the key modulo the bucket count) and waits in a two-entry queue.
// The front takes a new request only after pushing the last to the queue.
// The back answers a clear, a read of an unused slot or an unknown command
// from idle, and a read of a used slot through its read state. A count reads
// the chain head, then walks the chain until the key matches; a new key is
// inserted after the walk. The chain walk reads one pool entry per cycle
// from a single memory read port. The front takes the next request while
// the back works. The back starts an item only when the result register is
// empty or is being read in that cycle, so a waiting result stalls the back.
module chained_hash_key_counter_unit import chkc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    q_push, q_full, q_pop, q_empty;
   cls_type q_in, q_out;

   chkc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_data   (q_in)
   );

   chkc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_out)
   );

   chkc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/chkc_front.sv =====
// ============================================================================
// chkc_front
// Accepts requests and computes the bucket of the key through its fold and
// quotient states, then hands the classified request to the queue.
// ============================================================================
module chkc_front import chkc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    q_push,
   input  logic    q_full,
   output cls_type q_data
);

   front_state_type state_ff, state_in;
   req_type                item_ff;
   logic [X_BITS-1:0]      x_ff;
   logic [Q_BITS-1:0]      q_ff;
   logic [X_BITS-1:0]      fold_sum;
   logic [2*X_BITS-1:0]    quot_prod;
   logic [X_BITS-1:0]      rem_raw;
   logic [X_BITS-1:0]      rem_fix;
   logic                   accept;

   assign fold_sum = X_BITS'(item_ff.key[7:0])
                   + X_BITS'(item_ff.key[15:8]) * X_BITS'(FOLD1)
                   + X_BITS'(item_ff.key[23:16]) * X_BITS'(FOLD2);

   assign quot_prod = {{X_BITS{1'b0}}, x_ff} * (2*X_BITS)'(RECIP);

   assign rem_raw = x_ff - X_BITS'(q_ff) * X_BITS'(BUCKETS);
   assign rem_fix = (rem_raw >= X_BITS'(BUCKETS)) ? rem_raw - X_BITS'(BUCKETS) : rem_raw;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: if (req_push) state_in = FR_FOLD;
         FR_FOLD: state_in = FR_QUOT;
         FR_QUOT: state_in = FR_PUSH;
         FR_PUSH: if (!q_full) state_in = FR_IDLE;
         default: state_in = FR_IDLE;
      endcase
   end

   always_comb begin
      req_full      = (state_ff != FR_IDLE);
      accept        = req_push && !req_full;
      q_push        = (state_ff == FR_PUSH) && !q_full;
      q_data.req    = item_ff;
      q_data.bucket = rem_fix[BUCKET_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) item_ff <= req_data;
      if (state_ff == FR_FOLD) x_ff <= fold_sum;
      if (state_ff == FR_QUOT) q_ff <= quot_prod[RECIP_SHIFT +: Q_BITS];
   end

endmodule

// ===== hdl/chkc_queue.sv =====
// ============================================================================
// chkc_queue
// Two-entry queue of classified requests between front and back.
// ============================================================================
module chkc_queue import chkc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cls_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cls_type pop_data
);

   cls_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   always_comb begin
      full     = (fill_ff == 2'd2);
      empty    = (fill_ff == 2'd0);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in  = fill_ff + 2'(do_push) - 2'(do_pop);
      pop_data = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== hdl/chkc_back.sv =====
// ============================================================================
// chkc_back
// Holds the bucket heads and the entry pool, walks chains, updates counts,
// inserts new entries and drives the result register.
// ============================================================================
module chkc_back import chkc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  cls_type q_data,
   output logic    q_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam logic [USED_BITS-1:0] NIL = USED_BITS'(POOL_ENTRIES);

   logic [SLOT_BITS-1:0]  head_mem       [BUCKETS];
   logic [KEY_BITS-1:0]   pool_key_mem   [POOL_ENTRIES];
   logic [COUNT_BITS-1:0] pool_count_mem [POOL_ENTRIES];
   logic [USED_BITS-1:0]  pool_next_mem  [POOL_ENTRIES];

   back_state_type state_ff, state_in;
   cls_type               item_ff;
   logic [USED_BITS-1:0]  ptr_ff, ptr_in;
   logic [USED_BITS-1:0]  steps_ff, steps_in;
   logic [USED_BITS-1:0]  head_ff, head_in;
   logic [USED_BITS-1:0]  used_ff, used_in;
   logic [BUCKETS-1:0]    head_valid_ff, head_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [SLOT_BITS-1:0]  head_rd_ff;
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [COUNT_BITS-1:0] count_rd_ff;
   logic [USED_BITS-1:0]  next_rd_ff;

   logic [BUCKET_BITS-1:0] head_raddr;
   logic [SLOT_BITS-1:0]   pool_raddr;
   logic [SLOT_BITS-1:0]   pool_waddr;
   logic                   key_we, count_we, next_we, head_we;
   logic [COUNT_BITS-1:0]  count_wdata;

   logic                   out_free, start, emit;
   logic [USED_BITS-1:0]   head_val, walk_next, steps_next;
   logic                   key_match, walk_more, slot_used;
   logic [COUNT_BITS-1:0]  count_sat;

   assign out_free   = !rsp_valid_ff || rsp_pop;
   assign start      = (state_ff == BK_IDLE) && !q_empty && out_free;
   assign head_val   = head_valid_ff[item_ff.bucket] ? USED_BITS'(head_rd_ff) : NIL;
   assign key_match  = (key_rd_ff == item_ff.req.key);
   assign walk_next  = next_rd_ff;
   assign steps_next = steps_ff + USED_BITS'(1);
   assign walk_more  = (walk_next < used_ff) && (steps_next < USED_BITS'(POOL_ENTRIES));
   assign slot_used  = (USED_BITS'(q_data.req.slot) < used_ff);
   assign count_sat  = (count_rd_ff == COUNT_MAX) ? count_rd_ff
                                                  : count_rd_ff + COUNT_BITS'(1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (start) begin
               case (q_data.req.command)
                  CMD_COUNT: state_in = BK_HEAD;
                  CMD_READ:  if (slot_used) state_in = BK_READ;
                  default:   state_in = BK_IDLE;
               endcase
            end
         end
         BK_HEAD: state_in = (head_val < used_ff) ? BK_WALK : BK_MISS;
         BK_WALK: begin
            if (key_match)      state_in = BK_IDLE;
            else if (!walk_more) state_in = BK_MISS;
         end
         BK_MISS: state_in = BK_IDLE;
         BK_READ: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop         = start;
      head_raddr    = q_data.bucket;
      pool_raddr    = q_data.req.slot;
      pool_waddr    = ptr_ff[SLOT_BITS-1:0];
      key_we        = 1'b0;
      count_we      = 1'b0;
      next_we       = 1'b0;
      head_we       = 1'b0;
      count_wdata   = count_sat;
      ptr_in        = ptr_ff;
      steps_in      = steps_ff;
      head_in       = head_ff;
      used_in       = used_ff;
      head_valid_in = head_valid_ff;
      emit          = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         BK_IDLE: begin
            if (start) begin
               rsp_in.entry_index     = 8'd0;
               rsp_in.entry_key_out   = '0;
               rsp_in.entry_count_out = '0;
               case (q_data.req.command)
                  CMD_COUNT: ;
                  CMD_READ: begin
                     if (!slot_used) begin
                        emit               = 1'b1;
                        rsp_in.status      = ST_UNUSED;
                        rsp_in.entry_index = q_data.req.slot;
                     end
                  end
                  CMD_CLEAR: begin
                     emit          = 1'b1;
                     rsp_in.status = ST_CLEARED;
                     used_in       = '0;
                     head_valid_in = '0;
                  end
                  default: begin
                     emit          = 1'b1;
                     rsp_in.status = ST_UNUSED;
                  end
               endcase
            end
         end
         BK_HEAD: begin
            pool_raddr = head_val[SLOT_BITS-1:0];
            head_in    = head_val;
            ptr_in     = head_val;
            steps_in   = '0;
         end
         BK_WALK: begin
            if (key_match) begin
               count_we               = 1'b1;
               emit                   = 1'b1;
               rsp_in.status          = ST_FOUND;
               rsp_in.entry_index     = ptr_ff[SLOT_BITS-1:0];
               rsp_in.entry_key_out   = key_rd_ff;
               rsp_in.entry_count_out = count_sat;
            end else begin
               pool_raddr = walk_next[SLOT_BITS-1:0];
               ptr_in     = walk_next;
               steps_in   = steps_next;
            end
         end
         BK_MISS: begin
            emit                 = 1'b1;
            rsp_in.entry_key_out = item_ff.req.key;
            if (used_ff >= USED_BITS'(POOL_ENTRIES)) begin
               rsp_in.status          = ST_FULL;
               rsp_in.entry_index     = 8'd0;
               rsp_in.entry_count_out = '0;
            end else begin
               pool_waddr                    = used_ff[SLOT_BITS-1:0];
               key_we                        = 1'b1;
               count_we                      = 1'b1;
               next_we                       = 1'b1;
               head_we                       = 1'b1;
               count_wdata                   = COUNT_BITS'(1);
               head_valid_in[item_ff.bucket] = 1'b1;
               used_in                       = used_ff + USED_BITS'(1);
               rsp_in.status                 = ST_INSERTED;
               rsp_in.entry_index            = used_ff[SLOT_BITS-1:0];
               rsp_in.entry_count_out        = COUNT_BITS'(1);
            end
         end
         BK_READ: begin
            emit                   = 1'b1;
            rsp_in.status          = ST_READ;
            rsp_in.entry_index     = item_ff.req.slot;
            rsp_in.entry_key_out   = key_rd_ff;
            rsp_in.entry_count_out = count_rd_ff;
         end
         default: ;
      endcase
      rsp_in.entries_used = used_in;
      rsp_valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : rsp_valid_ff);
      rsp_empty    = !rsp_valid_ff;
      rsp_data     = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         used_ff       <= '0;
         head_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         head_valid_ff <= head_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) item_ff <= q_data;
      ptr_ff   <= ptr_in;
      steps_ff <= steps_in;
      head_ff  <= head_in;
      if (emit) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (head_we) head_mem[item_ff.bucket] <= used_ff[SLOT_BITS-1:0];
      head_rd_ff <= head_mem[head_raddr];
   end

   always_ff @(posedge clock) begin
      if (key_we)   pool_key_mem[pool_waddr]   <= item_ff.req.key;
      if (count_we) pool_count_mem[pool_waddr] <= count_wdata;
      if (next_we)  pool_next_mem[pool_waddr]  <= head_ff;
      key_rd_ff   <= pool_key_mem[pool_raddr];
      count_rd_ff <= pool_count_mem[pool_raddr];
      next_rd_ff  <= pool_next_mem[pool_raddr];
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_BITS'(POOL_ENTRIES))
      else $error("pool fill beyond capacity");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result written over a waiting result");

   a_walk_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_WALK) |-> (ptr_ff < used_ff))
      else $error("chain walk on an unused entry");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (used_ff == '0 && head_valid_ff == '0 && !rsp_valid_ff))
      else $error("table not empty after reset");

endmodule
